// ----- hdl/fscd_pkg.sv -----
// shared types and constants for the framed servo command decoder
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package fscd_pkg;

	// protocol bytes
	localparam logic [7:0] BYTE_OPEN  = 8'hFF;
	localparam logic [7:0] BYTE_CLOSE = 8'hFE;
	localparam logic [7:0] OP_MOVE    = 8'h01;
	localparam logic [7:0] OP_QUERY   = 8'h02;
	localparam logic [7:0] RESP_OK    = 8'h00;
	localparam logic [7:0] RESP_BAD   = 8'h01;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;

	// position codes in the low nibble of a move argument
	localparam logic [3:0] POS_LOW  = 4'd0;
	localparam logic [3:0] POS_MID  = 4'd1;
	localparam logic [3:0] POS_HIGH = 4'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH = 2'd2;

	// reset values
	localparam logic [15:0] PULSE_LOW_RESET  = 16'd1100;
	localparam logic [15:0] PULSE_MID_RESET  = 16'd1400;
	localparam logic [15:0] PULSE_HIGH_RESET = 16'd1700;
	localparam logic [15:0] SERVO_PULSE_RESET = 16'd1700;

	// parameter defaults
	localparam int unsigned NUM_SERVOS_DEF  = 4;
	localparam int unsigned FRAME_DEPTH_DEF = 16;
	localparam int unsigned CMD_FIFO_DEPTH  = 2;

	// result kinds
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;

	// beat positions of a response frame
	localparam int unsigned BEAT_W = 3;
	localparam logic [BEAT_W-1:0] BEAT_OPEN   = 3'd0;
	localparam logic [BEAT_W-1:0] BEAT_STATUS = 3'd1;
	localparam logic [BEAT_W-1:0] BEAT_ID     = 3'd2;
	localparam logic [BEAT_W-1:0] BEAT_HI     = 3'd3;
	localparam logic [BEAT_W-1:0] BEAT_LO     = 3'd4;
	localparam logic [BEAT_W-1:0] BEAT_CLOSE  = 3'd5;

	typedef enum logic [1:0] {
		CMD_SET_PULSE  = 2'd0,
		CMD_REPORT     = 2'd1,
		CMD_REPORT_BAD = 2'd2
	} cmd_kind_t;

	// one decoded command handed from front to back
	typedef struct packed {
		cmd_kind_t   kind;
		logic [3:0]  servo;
		logic [15:0] pulse;
	} cmd_t;

endpackage

// ----- hdl/fscd_cmd_fifo.sv -----
// short register queue of decoded commands between front and back
// depends on fscd_pkg for the command type
`timescale 1ns / 1ps

module fscd_cmd_fifo #(
	parameter int unsigned DEPTH = fscd_pkg::CMD_FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  fscd_pkg::cmd_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output fscd_pkg::cmd_t rd_data,
	output logic           empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	fscd_pkg::cmd_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hdl/fscd_front.sv -----
// front part: frame tracking, byte capture, command classification, pulse registers
// depends on fscd_pkg
`timescale 1ns / 1ps

module fscd_front #(
	parameter int unsigned NUM_SERVOS  = fscd_pkg::NUM_SERVOS_DEF,
	parameter int unsigned FRAME_DEPTH = fscd_pkg::FRAME_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	input  logic [7:0]                     byte_data,
	input  logic                           cfg_wr,
	input  logic [fscd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                    cfg_wdata,
	output logic                           cmd_push,
	output fscd_pkg::cmd_t                 cmd_data
);

	localparam int unsigned CNT_W = $clog2(FRAME_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_DEPTH);
	localparam logic [CNT_W-1:0] CNT_CMD = CNT_W'(0);
	localparam logic [CNT_W-1:0] CNT_ARG = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(2);
	localparam logic [4:0] SERVO_LIMIT = 5'(NUM_SERVOS);

	logic             in_frame_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       cmd_byte_q;
	logic [7:0]       arg_byte_q;
	logic [15:0]      pulse_low_q;
	logic [15:0]      pulse_mid_q;
	logic [15:0]      pulse_high_q;

	logic       is_open;
	logic       is_close;
	logic [3:0] arg_hi;
	logic [3:0] arg_lo;
	logic       move_ok;
	logic       query_cmd;
	logic       query_bad;
	logic       long_enough;

	assign is_open     = (byte_data == fscd_pkg::BYTE_OPEN);
	assign is_close    = (byte_data == fscd_pkg::BYTE_CLOSE);
	assign arg_hi      = arg_byte_q[7:4];
	assign arg_lo      = arg_byte_q[3:0];
	assign long_enough = (count_q >= CNT_MIN);
	assign move_ok     = (cmd_byte_q == fscd_pkg::OP_MOVE)
		&& ({1'b0, arg_hi} < SERVO_LIMIT) && (arg_lo <= fscd_pkg::POS_HIGH);
	assign query_cmd   = (cmd_byte_q == fscd_pkg::OP_QUERY);
	assign query_bad   = ({1'b0, arg_lo} >= SERVO_LIMIT);
	assign cmd_push    = byte_valid && is_close && in_frame_q && long_enough
		&& (move_ok || query_cmd);

	always_comb begin
		cmd_data.servo = arg_lo;
		cmd_data.pulse = pulse_high_q;
		if (move_ok) begin
			cmd_data.kind  = fscd_pkg::CMD_SET_PULSE;
			cmd_data.servo = arg_hi;
		end else if (query_bad) begin
			cmd_data.kind = fscd_pkg::CMD_REPORT_BAD;
		end else begin
			cmd_data.kind = fscd_pkg::CMD_REPORT;
		end
		case (arg_lo)
			fscd_pkg::POS_LOW: begin
				cmd_data.pulse = pulse_low_q;
			end
			fscd_pkg::POS_MID: begin
				cmd_data.pulse = pulse_mid_q;
			end
			default: begin
				cmd_data.pulse = pulse_high_q;
			end
		endcase
	end

	// captured bytes only read after both were written in the frame
	always_ff @(posedge clk) begin
		if (byte_valid && !is_open && !is_close && in_frame_q) begin
			if (count_q == CNT_CMD) begin
				cmd_byte_q <= byte_data;
			end
			if (count_q == CNT_ARG) begin
				arg_byte_q <= byte_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
		end else if (byte_valid) begin
			if (is_open) begin
				in_frame_q <= 1'b1;
				count_q    <= '0;
			end else if (is_close) begin
				in_frame_q <= 1'b0;
			end else if (in_frame_q && (count_q < CNT_MAX)) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_low_q  <= fscd_pkg::PULSE_LOW_RESET;
			pulse_mid_q  <= fscd_pkg::PULSE_MID_RESET;
			pulse_high_q <= fscd_pkg::PULSE_HIGH_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				fscd_pkg::REG_PULSE_LOW: begin
					pulse_low_q <= cfg_wdata;
				end
				fscd_pkg::REG_PULSE_MID: begin
					pulse_mid_q <= cfg_wdata;
				end
				fscd_pkg::REG_PULSE_HIGH: begin
					pulse_high_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hdl/fscd_back.sv -----
// back part: executes queued commands, holds servo pulse widths, drives result register
// depends on fscd_pkg
`timescale 1ns / 1ps

module fscd_back #(
	parameter int unsigned NUM_SERVOS = fscd_pkg::NUM_SERVOS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fscd_pkg::cmd_t cmd_head,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	input  logic           out_pop,
	output logic           out_valid,
	output logic           out_kind,
	output logic [7:0]     out_tx,
	output logic           out_last,
	output logic [1:0]     out_servo,
	output logic [15:0]    out_pulse
);

	localparam int unsigned SIDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

	logic [15:0]                 pulse_q [NUM_SERVOS];
	logic [fscd_pkg::BEAT_W-1:0] beat_q;
	logic                        out_valid_q;
	logic                        out_kind_q;
	logic [7:0]                  out_tx_q;
	logic                        out_last_q;
	logic [1:0]                  out_servo_q;
	logic [15:0]                 out_pulse_q;

	logic              emit;
	logic              last_beat;
	logic [SIDX_W-1:0] sidx;
	logic [15:0]       cur_pulse;
	logic [7:0]        beat_byte;
	logic              is_move;

	assign sidx      = cmd_head.servo[SIDX_W-1:0];
	assign cur_pulse = pulse_q[sidx];
	assign is_move   = (cmd_head.kind == fscd_pkg::CMD_SET_PULSE);
	assign emit      = !cmd_empty && (!out_valid_q || out_pop);
	assign cmd_pop   = emit && last_beat;

	always_comb begin
		case (cmd_head.kind)
			fscd_pkg::CMD_SET_PULSE: begin
				last_beat = 1'b1;
			end
			fscd_pkg::CMD_REPORT: begin
				last_beat = (beat_q == fscd_pkg::BEAT_CLOSE);
			end
			default: begin
				last_beat = (beat_q == fscd_pkg::BEAT_LO);
			end
		endcase
	end

	always_comb begin
		case (beat_q)
			fscd_pkg::BEAT_OPEN: begin
				beat_byte = fscd_pkg::BYTE_OPEN;
			end
			fscd_pkg::BEAT_STATUS: begin
				beat_byte = (cmd_head.kind == fscd_pkg::CMD_REPORT_BAD)
					? fscd_pkg::RESP_BAD : fscd_pkg::RESP_OK;
			end
			fscd_pkg::BEAT_ID: begin
				beat_byte = (cmd_head.kind == fscd_pkg::CMD_REPORT_BAD)
					? fscd_pkg::BYTE_ZERO : {4'h0, cmd_head.servo};
			end
			fscd_pkg::BEAT_HI: begin
				beat_byte = (cmd_head.kind == fscd_pkg::CMD_REPORT_BAD)
					? fscd_pkg::BYTE_ZERO : cur_pulse[15:8];
			end
			fscd_pkg::BEAT_LO: begin
				beat_byte = (cmd_head.kind == fscd_pkg::CMD_REPORT_BAD)
					? fscd_pkg::BYTE_CLOSE : cur_pulse[7:0];
			end
			default: begin
				beat_byte = fscd_pkg::BYTE_CLOSE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				pulse_q[i] <= fscd_pkg::SERVO_PULSE_RESET;
			end
		end else if (emit && is_move) begin
			pulse_q[sidx] <= cmd_head.pulse;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= fscd_pkg::BEAT_OPEN;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				beat_q <= last_beat ? fscd_pkg::BEAT_OPEN : beat_q + fscd_pkg::BEAT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_last_q <= last_beat;
			if (is_move) begin
				out_kind_q  <= fscd_pkg::KIND_UPDATE;
				out_tx_q    <= fscd_pkg::BYTE_ZERO;
				out_servo_q <= cmd_head.servo[1:0];
				out_pulse_q <= cmd_head.pulse;
			end else begin
				out_kind_q  <= fscd_pkg::KIND_BYTE;
				out_tx_q    <= beat_byte;
				out_servo_q <= 2'd0;
				out_pulse_q <= 16'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_tx    = out_tx_q;
	assign out_last  = out_last_q;
	assign out_servo = out_servo_q;
	assign out_pulse = out_pulse_q;

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		beat_q <= fscd_pkg::BEAT_CLOSE)
		else $error("beat counter past close byte");

	a_mid_frame_head: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_q != fscd_pkg::BEAT_OPEN) |-> !cmd_empty)
		else $error("response in progress without queued command");

	a_bad_short: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd_empty && (cmd_head.kind == fscd_pkg::CMD_REPORT_BAD))
		|-> (beat_q != fscd_pkg::BEAT_CLOSE))
		else $error("error response longer than five bytes");

	a_update_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == fscd_pkg::KIND_UPDATE)) |-> out_last_q)
		else $error("servo update not marked last");

endmodule

// ----- hdl/framed_servo_command_decoder_unit.sv -----
// top level of the framed servo command decoder
// depends on fscd_pkg, fscd_front, fscd_cmd_fifo, fscd_back
`timescale 1ns / 1ps

// framed servo command decoder: takes one received byte per beat on the push side
// (push/full) and gives results on the pop side (empty/pop). a 0xFF byte opens a
// frame, the first two bytes inside are command and argument, a 0xFE byte closes it.
// a valid move (0x01) gives one servo update beat with kind 1; a query (0x02) gives
// a response frame of six bytes (FF 00 id hi lo FE), or five (FF 01 00 00 FE) for a
// servo number out of range, one byte per beat with kind 0; last marks the final
// beat caused by the closing byte. anything else gives no result. the front takes a
// byte every cycle and pushes a decoded command into a two-entry queue; the back
// drains that queue into a single output register at one result beat per cycle
// while it is free or popped. input stalls (full high) only when two decoded
// commands are already waiting. the user writes the three pulse width registers
// on the cfg port (always ready) only while the block is idle; this is not enforced.
module framed_servo_command_decoder_unit #(
	parameter int unsigned NUM_SERVOS  = fscd_pkg::NUM_SERVOS_DEF,
	parameter int unsigned FRAME_DEPTH = fscd_pkg::FRAME_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// byte input, queue style
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     rx_byte,
	// result output, queue style
	output logic                           empty,
	input  logic                           pop,
	output logic                           kind,
	output logic [7:0]                     tx_byte,
	output logic                           last,
	output logic [1:0]                     servo_index,
	output logic [15:0]                    pulse_us,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fscd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);

	logic           byte_beat;
	logic           cmd_push;
	fscd_pkg::cmd_t cmd_in;
	fscd_pkg::cmd_t cmd_head;
	logic           cmd_full;
	logic           cmd_empty;
	logic           cmd_pop;
	logic           out_valid;

	// a byte is taken only while the command queue has room, even if it
	// ends up not closing a frame
	assign full      = cmd_full;
	assign byte_beat = push && !cmd_full;

	// pulse registers accept a write every cycle
	assign cfg_ready = 1'b1;

	fscd_front #(
		.NUM_SERVOS  (NUM_SERVOS),
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_beat),
		.byte_data  (rx_byte),
		.cfg_wr     (cfg_valid),
		.cfg_idx    (cfg_index),
		.cfg_wdata  (cfg_data),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_in)
	);

	// decouples byte intake from response generation
	fscd_cmd_fifo #(
		.DEPTH (fscd_pkg::CMD_FIFO_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty)
	);

	fscd_back #(
		.NUM_SERVOS (NUM_SERVOS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_head  (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.out_pop   (pop),
		.out_valid (out_valid),
		.out_kind  (kind),
		.out_tx    (tx_byte),
		.out_last  (last),
		.out_servo (servo_index),
		.out_pulse (pulse_us)
	);

	// oldest result sits in the back's output register
	assign empty = !out_valid;

endmodule
